/* hw/rtl/kmer_histogram_counter_assert.svh */
// Assertion macros for the k-mer histogram counter.
// Used by khc_table in this folder; no other dependencies.
`ifndef KMER_HISTOGRAM_COUNTER_ASSERT_SVH
`define KMER_HISTOGRAM_COUNTER_ASSERT_SVH
`ifndef SYNTH
// Property checked every clock edge outside reset.
`define KHC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Property checked every clock edge, reset included.
`define KHC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define KHC_ASSERT(lbl, prop, msg)
`define KHC_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

/* hw/rtl/khc_pkg.sv */
// Shared types and constants for the k-mer histogram counter.
// No dependencies; used by khc_front, khc_table and the top level.
package khc_pkg;

  localparam int MAX_KMER    = 7;
  localparam int ADDR_W      = 2 * MAX_KMER;
  localparam int TABLE_DEPTH = 1 << ADDR_W;
  localparam int CNT_W       = 32;
  localparam int LEN_W       = 3;
  localparam int FILL_W      = 3;

  localparam logic [LEN_W-1:0] KLEN_RESET = 3'd5;

  // Action codes of an input transaction
  localparam logic [1:0] ACT_PUSH = 2'd0;
  localparam logic [1:0] ACT_ADD  = 2'd1;
  localparam logic [1:0] ACT_READ = 2'd2;

  // Table operation carried down the pipeline
  typedef enum logic [1:0] {
    OP_NONE,
    OP_INC,
    OP_ADD,
    OP_READ
  } op_t;

  typedef struct packed {
    logic [1:0]        action;
    logic [1:0]        base_code;
    logic              interval_start;
    logic [ADDR_W-1:0] entry_index;
    logic [CNT_W-1:0]  add_amount;
  } in_t;

  typedef struct packed {
    logic [CNT_W-1:0] entry_count;
    logic [CNT_W-1:0] windows_counted;
  } out_t;

  // Request from the window front end to the table
  typedef struct packed {
    op_t               op;
    logic [ADDR_W-1:0] addr;
    logic [CNT_W-1:0]  amount;
    logic [CNT_W-1:0]  total;
  } req_t;

  // Mask of the low 2*bases bits of a packed window
  function automatic logic [ADDR_W-1:0] win_mask(input logic [LEN_W:0] bases);
    logic [ADDR_W-1:0] m;
    m = '0;
    for (int i = 0; i < ADDR_W; i++) begin
      m[i] = (i < 2 * int'(bases));
    end
    return m;
  endfunction

  // Saturating add of two counts
  function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                               input logic [CNT_W-1:0] b);
    logic [CNT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[CNT_W] ? {CNT_W{1'b1}} : s[CNT_W-1:0];
  endfunction

endpackage

/* hw/rtl/khc_front.sv */
// Window front end: length register, rolling k-mer window, fill level, total.
// Depends on khc_pkg; turns each accepted transaction into a table request.
module khc_front (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [khc_pkg::LEN_W-1:0] cfg_len,
  input  logic                      acc,
  input  khc_pkg::in_t              in_item,
  output khc_pkg::req_t             req
);

  logic [khc_pkg::LEN_W-1:0]  klen_r;
  logic [khc_pkg::ADDR_W-1:0] win_r, win_nxt;
  logic [khc_pkg::FILL_W-1:0] fill_r, fill_nxt;
  logic [khc_pkg::CNT_W-1:0]  total_r, total_nxt;

  logic [khc_pkg::LEN_W:0]    n;
  logic [khc_pkg::ADDR_W-1:0] win_cur;
  logic [khc_pkg::FILL_W:0]   fill_cur, fill_inc;
  logic                       counted;

  // Effective length: zero acts as one
  assign n = (klen_r == '0) ? 4'd1 : {1'b0, klen_r};

  always_comb begin
    win_cur   = in_item.interval_start ? '0 : win_r;
    fill_cur  = in_item.interval_start ? '0 : {1'b0, fill_r};
    counted   = (fill_cur >= n);
    fill_inc  = fill_cur + 4'd1;
    win_nxt   = ((win_cur & khc_pkg::win_mask(n - 4'd1)) << 2)
                | {{(khc_pkg::ADDR_W-2){1'b0}}, in_item.base_code};
    fill_nxt  = (fill_inc > n) ? n[khc_pkg::FILL_W-1:0] : fill_inc[khc_pkg::FILL_W-1:0];
    total_nxt = (counted && total_r != {khc_pkg::CNT_W{1'b1}}) ? total_r + 1'b1 : total_r;

    req.amount = in_item.add_amount;
    req.total  = total_r;
    req.addr   = in_item.entry_index;
    req.op     = khc_pkg::OP_NONE;
    unique case (in_item.action)
      khc_pkg::ACT_PUSH: begin
        req.addr  = win_cur & khc_pkg::win_mask(n);
        req.op    = counted ? khc_pkg::OP_INC : khc_pkg::OP_NONE;
        req.total = total_nxt;
      end
      khc_pkg::ACT_ADD:  req.op = khc_pkg::OP_ADD;
      khc_pkg::ACT_READ: req.op = khc_pkg::OP_READ;
      default:           req.op = khc_pkg::OP_NONE;
    endcase
  end

  // Window state advances on accepted pushes only
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      klen_r  <= khc_pkg::KLEN_RESET;
      win_r   <= '0;
      fill_r  <= '0;
      total_r <= '0;
    end else begin
      if (cfg_we) begin
        klen_r <= cfg_len;
      end
      if (acc && in_item.action == khc_pkg::ACT_PUSH) begin
        win_r   <= win_nxt;
        fill_r  <= fill_nxt;
        total_r <= total_nxt;
      end
    end
  end

endmodule

/* hw/rtl/khc_table.sv */
// Count table: one-port-read, one-port-write memory with read-modify-write,
// write forwarding and a clearing pass after reset. Depends on khc_pkg.
`include "kmer_histogram_counter_assert.svh"
module khc_table (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          req_valid,
  input  khc_pkg::req_t req,
  input  logic          adv,
  output logic          s1_valid,
  output khc_pkg::out_t s1_res,
  output logic          busy
);

  logic [khc_pkg::CNT_W-1:0] mem [khc_pkg::TABLE_DEPTH];

  logic [khc_pkg::CNT_W-1:0]  rdata_r;
  logic                       s1_valid_r;
  khc_pkg::req_t              s1_req_r;
  logic                       fwd_valid_r;
  logic [khc_pkg::ADDR_W-1:0] fwd_addr_r;
  logic [khc_pkg::CNT_W-1:0]  fwd_data_r;
  logic                       clr_busy_r;
  logic [khc_pkg::ADDR_W-1:0] clr_addr_r;

  logic [khc_pkg::CNT_W-1:0]  cur, upd;
  logic                       s1_we, we;
  logic [khc_pkg::ADDR_W-1:0] wa;
  logic [khc_pkg::CNT_W-1:0]  wd;

  // Modify: current value comes from the last write when it hit this entry
  always_comb begin
    cur = (fwd_valid_r && fwd_addr_r == s1_req_r.addr) ? fwd_data_r : rdata_r;
    upd = cur;
    s1_res.entry_count     = '0;
    s1_res.windows_counted = s1_req_r.total;
    unique case (s1_req_r.op)
      khc_pkg::OP_INC:  upd = khc_pkg::sat_add(cur, {{(khc_pkg::CNT_W-1){1'b0}}, 1'b1});
      khc_pkg::OP_ADD: begin
        upd = khc_pkg::sat_add(cur, s1_req_r.amount);
        s1_res.entry_count = upd;
      end
      khc_pkg::OP_READ: s1_res.entry_count = cur;
      khc_pkg::OP_NONE: upd = cur;
    endcase
  end

  assign s1_we    = s1_valid_r && adv &&
                    (s1_req_r.op == khc_pkg::OP_INC || s1_req_r.op == khc_pkg::OP_ADD);
  assign we       = clr_busy_r || s1_we;
  assign wa       = clr_busy_r ? clr_addr_r : s1_req_r.addr;
  assign wd       = clr_busy_r ? '0 : upd;
  assign s1_valid = s1_valid_r;
  assign busy     = clr_busy_r;

  // Memory array: write-back port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (req_valid) begin
      rdata_r <= mem[req.addr];
    end
  end

  // Stage 1 payload and forwarding data
  always_ff @(posedge clk) begin
    if (req_valid) begin
      s1_req_r <= req;
    end
    if (we) begin
      fwd_addr_r <= wa;
      fwd_data_r <= wd;
    end
  end

  // Control: stage valid, forwarding valid, clearing sweep
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      fwd_valid_r <= 1'b0;
      clr_busy_r  <= 1'b1;
      clr_addr_r  <= '0;
    end else begin
      if (req_valid) begin
        s1_valid_r <= 1'b1;
      end else if (adv) begin
        s1_valid_r <= 1'b0;
      end
      if (we) begin
        fwd_valid_r <= 1'b1;
      end
      if (clr_busy_r) begin
        clr_addr_r <= clr_addr_r + 1'b1;
        if (clr_addr_r == {khc_pkg::ADDR_W{1'b1}}) begin
          clr_busy_r <= 1'b0;
        end
      end
    end
  end

  `KHC_ASSERT(a_no_req_in_clear, req_valid |-> !clr_busy_r, "request during clearing pass")
  `KHC_ASSERT(a_no_req_on_stall, (s1_valid_r && !adv) |-> !req_valid, "request into held stage")
  `KHC_ASSERT(a_hold_stage, (s1_valid_r && !adv) |=> (s1_valid_r && $stable(s1_req_r)), "stage 1 lost while held")
  `KHC_ASSERT(a_clear_done, $fell(clr_busy_r) |-> ($past(clr_addr_r) == {khc_pkg::ADDR_W{1'b1}}), "clearing ended early")

endmodule

/* hw/rtl/kmer_histogram_counter.sv */
// K-mer histogram counter top level: channels, output register, stall logic.
// Depends on khc_pkg, khc_front and khc_table.
//
// Usage:
//   in_valid/in_stall/in_data carry one transaction (push base, add amount to
//   an entry, or read an entry). out_valid/out_stall/out_data return exactly
//   one result per input transaction, in order.
//   cfg_valid/cfg_ready/cfg_kmer_len write the window length; write it only
//   while no transaction is in flight. cfg_ready is always high.
// Throughput: one transaction per cycle while in_stall is low; the table read-modify-write takes a
//   registered memory read, a modify stage with forwarding from the previous
//   write, and the write-back, so back-to-back hits to one entry still run at
//   full rate.
// Results: an accepted input passes through stage 1, then the output register.
// Reset: window, fill level and totals clear at once; the table is then
//   cleared one entry a cycle, all 16384 entries, with in_stall held high.
// Stall: while out_stall holds the output register full, one more result
//   waits in the modify stage; after that in_stall rises.
module kmer_histogram_counter (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  khc_pkg::in_t              in_data,
  output logic                      out_valid,
  input  logic                      out_stall,
  output khc_pkg::out_t             out_data,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [khc_pkg::LEN_W-1:0] cfg_kmer_len
);

  logic          out_valid_r;
  khc_pkg::out_t out_data_r;
  logic          adv, acc, s1_valid, busy;
  khc_pkg::req_t req;
  khc_pkg::out_t s1_res;

  // Stage 1 moves on when the output register is empty or being taken
  assign adv       = !out_valid_r || !out_stall;
  assign in_stall  = busy || (s1_valid && !adv);
  assign acc       = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  khc_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg_we  (cfg_valid && cfg_ready),
    .cfg_len (cfg_kmer_len),
    .acc     (acc),
    .in_item (in_data),
    .req     (req)
  );

  khc_table u_table (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (acc),
    .req       (req),
    .adv       (adv),
    .s1_valid  (s1_valid),
    .s1_res    (s1_res),
    .busy      (busy)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s1_valid) begin
      out_data_r <= s1_res;
    end
  end

endmodule

/* verif/kmer_count_checker.sv */
// Scoreboard for the k-mer histogram counter: watches all three channels,
// keeps its own count table and window, and compares every result in order.
// Depends on khc_pkg for the payload types and sizes.
module kmer_count_checker
  import khc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_stall,
  input  in_t              in_data,
  input  logic             out_valid,
  input  logic             out_stall,
  input  out_t             out_data,
  input  logic             cfg_valid,
  input  logic             cfg_ready,
  input  logic [LEN_W-1:0] cfg_kmer_len,
  output int               mismatches,
  output int               pending
);

  // Shadow copy of the block's state
  logic [CNT_W-1:0]  hist_table [TABLE_DEPTH];
  logic [ADDR_W-1:0] win_bits;
  int                fill_cnt;
  logic [CNT_W-1:0]  win_total;
  logic [LEN_W-1:0]  len_reg;
  out_t              due_counts [$];

  // Low 2*bases bits set
  function automatic logic [ADDR_W-1:0] base_field_mask(input int bases);
    if (bases >= MAX_KMER) return '1;
    return ADDR_W'((1 << (2 * bases)) - 1);
  endfunction

  // a + b, stuck at all ones on overflow
  function automatic logic [CNT_W-1:0] capped_sum(input logic [CNT_W-1:0] a,
                                                  input logic [CNT_W-1:0] b);
    return (b > ~a) ? '1 : a + b;
  endfunction

  // Update the shadow state for one accepted transaction, queue its result
  task automatic apply_action(input in_t t);
    int                n;
    logic [ADDR_W-1:0] w;
    out_t              r;
    // a length of zero behaves as one base
    n = (len_reg == '0) ? 1 : int'(len_reg);
    r = '0;
    case (t.action)
      ACT_PUSH: begin
        if (t.interval_start) begin
          win_bits = '0;
          fill_cnt = 0;
        end
        // full window is counted before the new base shifts in
        if (fill_cnt >= n) begin
          w = win_bits & base_field_mask(n);
          hist_table[w] = capped_sum(hist_table[w], 1);
          if (win_total != '1) win_total = win_total + 1;
        end
        win_bits = ((win_bits & base_field_mask(n - 1)) << 2) | ADDR_W'(t.base_code);
        fill_cnt = (fill_cnt + 1 > n) ? n : fill_cnt + 1;
      end
      ACT_ADD: begin
        hist_table[t.entry_index] = capped_sum(hist_table[t.entry_index], t.add_amount);
        r.entry_count = hist_table[t.entry_index];
      end
      ACT_READ: r.entry_count = hist_table[t.entry_index];
      default: ;
    endcase
    r.windows_counted = win_total;
    due_counts.push_back(r);
  endtask

  // Compare one result transaction with the oldest expectation
  task automatic check_result(input out_t got);
    out_t exp_r;
    if (due_counts.size() == 0) begin
      if (mismatches < 10)
        $display("[%0t] unexpected result: entry_count=%h windows_counted=%h",
                 $realtime, got.entry_count, got.windows_counted);
      mismatches++;
    end else begin
      exp_r = due_counts.pop_front();
      if (exp_r.entry_count != got.entry_count ||
          exp_r.windows_counted != got.windows_counted) begin
        if (mismatches < 10)
          $display("[%0t] mismatch: entry_count exp %h got %h, windows_counted exp %h got %h",
                   $realtime, exp_r.entry_count, got.entry_count,
                   exp_r.windows_counted, got.windows_counted);
        mismatches++;
      end
    end
  endtask

  // All channels sampled at the rising edge
  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TABLE_DEPTH; i++) hist_table[i] = '0;
      win_bits   = '0;
      fill_cnt   = 0;
      win_total  = '0;
      len_reg    = KLEN_RESET;
      mismatches = 0;
      due_counts.delete();
    end else begin
      if (cfg_valid && cfg_ready) len_reg = cfg_kmer_len;
      if (in_valid && !in_stall) apply_action(in_data);
      if (out_valid && !out_stall) check_result(out_data);
    end
    pending = due_counts.size();
  end

endmodule

/* verif/tb_top.sv */
// Testbench top for the k-mer histogram counter: clock, reset, stimulus,
// random idling on both channels and the final verdict.
// Depends on khc_pkg, kmer_histogram_counter and kmer_count_checker.
module tb_top;
  import khc_pkg::*;

  localparam logic [1:0] ACT_UNUSED  = 2'd3;
  localparam int         CYCLE_LIMIT = 200000;
  localparam int         HOLD_CYCLES = 200;
  localparam int         PHASE_ITEMS = 125;

  logic             clk          = 1'b0;
  logic             rst_n        = 1'b0;
  logic             in_valid     = 1'b0;
  logic             in_stall;
  in_t              in_data      = '0;
  logic             out_valid;
  logic             out_stall    = 1'b0;
  out_t             out_data;
  logic             cfg_valid    = 1'b0;
  logic             cfg_ready;
  logic [LEN_W-1:0] cfg_kmer_len = '0;

  int                mismatches;
  int                pending;
  int                idle_pct  = 0;
  int                stall_pct = 0;
  bit                hold_req  = 1'b0;
  int                cycle_cnt = 0;
  logic [ADDR_W-1:0] recent_bases = '0;

  kmer_histogram_counter u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data     (out_data),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_kmer_len (cfg_kmer_len)
  );

  kmer_count_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data     (out_data),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_kmer_len (cfg_kmer_len),
    .mismatches   (mismatches),
    .pending      (pending)
  );

  always #2 clk = ~clk;

  // Run limit
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Result side: random stall, plus one long hold-off when requested
  int hold_left = 0;
  bit hold_done = 1'b0;
  always @(negedge clk) begin
    if (hold_req && !hold_done) begin
      hold_left = HOLD_CYCLES;
      hold_done = 1'b1;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  function automatic in_t mk(input logic [1:0] act, input logic [1:0] base,
                             input logic istart, input logic [ADDR_W-1:0] idx,
                             input logic [CNT_W-1:0] amt);
    in_t t;
    t.action         = act;
    t.base_code      = base;
    t.interval_start = istart;
    t.entry_index    = idx;
    t.add_amount     = amt;
    return t;
  endfunction

  // Index that is likely to hit a counted window
  function automatic logic [ADDR_W-1:0] pick_index();
    if ($urandom_range(0, 1))
      return ADDR_W'($urandom);
    return recent_bases & ADDR_W'((1 << (2 * $urandom_range(1, MAX_KMER))) - 1);
  endfunction

  // Mostly base pushes with occasional interval restarts, merges and reads
  function automatic in_t random_item();
    in_t t;
    int  r;
    t = mk(ACT_PUSH, 2'($urandom), 1'b0, ADDR_W'($urandom), $urandom);
    r = $urandom_range(0, 99);
    if (r < 70) begin
      t.interval_start = ($urandom_range(0, 39) == 0);
      recent_bases = {recent_bases[ADDR_W-3:0], t.base_code};
    end else if (r < 80) begin
      t.action      = ACT_ADD;
      t.entry_index = pick_index();
      case ($urandom_range(0, 3))
        0: t.add_amount = 32'hFFFF_FFFF - $urandom_range(0, 3);
        1: t.add_amount = $urandom_range(0, 15);
        default: ;
      endcase
    end else if (r < 95) begin
      t.action      = ACT_READ;
      t.entry_index = pick_index();
    end else begin
      t.action = ACT_UNUSED;
    end
    return t;
  endfunction

  // One input transaction; entered and left just after a falling edge
  task automatic send_item(input in_t t);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= t;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // Wait until every expected result has come back
  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  task automatic write_len(input logic [LEN_W-1:0] len);
    cfg_valid    <= 1'b1;
    cfg_kmer_len <= len;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Stimulus
  initial begin
    logic [LEN_W-1:0] lens [8];
    lens = '{3'd1, 3'd7, 3'd0, 3'd3, 3'd2, 3'd6, 3'd4, 3'd5};

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    write_len(3'd5);

    // Directed: empty read, entry saturation by add and by window count
    send_item(mk(ACT_READ, 2'd3, 1'b1, '0, '1));
    send_item(mk(ACT_ADD, 2'd0, 1'b0, '0, 32'hFFFF_FFF0));
    send_item(mk(ACT_ADD, 2'd3, 1'b1, '0, 32'h0000_0020));
    send_item(mk(ACT_PUSH, 2'd0, 1'b1, '1, '1));
    repeat (5) send_item(mk(ACT_PUSH, 2'd0, 1'b0, '0, '0));
    send_item(mk(ACT_READ, 2'd0, 1'b0, '0, '0));
    // all-ones window, restarted by an interval start
    send_item(mk(ACT_PUSH, 2'd3, 1'b1, '0, '0));
    repeat (5) send_item(mk(ACT_PUSH, 2'd3, 1'b0, '0, '0));
    send_item(mk(ACT_READ, 2'd1, 1'b1, 14'h03FF, '0));
    // top entry, max and zero amounts, unused action
    send_item(mk(ACT_ADD, 2'd2, 1'b0, '1, '1));
    send_item(mk(ACT_ADD, 2'd1, 1'b1, '1, '0));
    send_item(mk(ACT_READ, 2'd0, 1'b0, '1, '0));
    send_item(mk(ACT_UNUSED, 2'd3, 1'b1, '1, '1));
    send_item(mk(ACT_UNUSED, 2'd0, 1'b0, '0, '0));
    drain();

    // Random phases, each with its own length and one of four idling modes
    for (int p = 0; p < 8; p++) begin
      write_len(lens[p]);
      case (p % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 59; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 59; end
        default: begin idle_pct = 34; stall_pct = 34; end
      endcase
      // long hold-off on the result side while inputs keep coming
      if (p == 4) hold_req = 1'b1;
      for (int i = 0; i < PHASE_ITEMS; i++) send_item(random_item());
      drain();
    end

    if (mismatches == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
